### rtl/bpr_pkg.sv
`timescale 1ns / 1ps

package bpr_pkg;

    localparam int PACKET_BYTES_DEF = 512;
    localparam int LEN_W            = 10;
    localparam int MAX_RES          = 3;
    localparam int RES_DEPTH        = 8;
    localparam logic [7:0] ERROR_LIMIT_RST = 8'd10;

    localparam logic [1:0] ACT_BYTE    = 2'd0;
    localparam logic [1:0] ACT_TIMEOUT = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    localparam logic [2:0] KIND_TX      = 3'd0;
    localparam logic [2:0] KIND_DATA    = 3'd1;
    localparam logic [2:0] KIND_ACCEPT  = 3'd2;
    localparam logic [2:0] KIND_ABANDON = 3'd3;
    localparam logic [2:0] KIND_GAVEUP  = 3'd4;

    localparam logic [7:0] CH_ETX    = 8'h03;
    localparam logic [7:0] CH_ENQ    = 8'h05;
    localparam logic [7:0] CH_DLE    = 8'h10;
    localparam logic [7:0] CH_NAK    = 8'h15;
    localparam logic [7:0] CH_B      = 8'h42;
    localparam logic [3:0] DIGIT_HI  = 4'h3;
    localparam logic [7:0] ESC_MASK  = 8'h1F;
    localparam logic [7:0] COUNT_MAX = 8'hFF;
    localparam logic [3:0] SEQ_LAST  = 4'd9;

    typedef enum logic [2:0] {
        PH_HALTED = 3'd0,
        PH_DLE    = 3'd1,
        PH_B      = 3'd2,
        PH_SEQ    = 3'd3,
        PH_DATA   = 3'd4,
        PH_SUM    = 3'd5
    } t_phase;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] line_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]       kind;
        logic [7:0]       value;
        logic [LEN_W-1:0] packet_length;
        logic             last;
    } t_out_item;

    typedef struct packed {
        logic [1:0]             count;
        t_out_item [MAX_RES-1:0] items;
    } t_push;

    function automatic logic [7:0] sum_add(input logic [7:0] s, input logic [7:0] ch);
        logic [7:0] rot;
        logic [8:0] u;
        rot = {s[6:0], s[7]};
        u   = {1'b0, rot} + {1'b0, ch};
        return u[8] ? (u[7:0] + 8'd1) : u[7:0];
    endfunction

endpackage

### rtl/bpr_core.sv
`timescale 1ns / 1ps

module bpr_core #(
    parameter int PACKET_BYTES = bpr_pkg::PACKET_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  bpr_pkg::t_in_item   i_item,
    input  logic [7:0]          i_error_limit,
    output bpr_pkg::t_push      o_push
);
    import bpr_pkg::*;

    localparam int BC_W = $clog2(PACKET_BYTES + 1);

    t_phase           r_phase, n_phase;
    logic             r_esc, n_esc;
    logic [7:0]       r_sum, n_sum;
    logic [BC_W-1:0]  r_bc, n_bc;
    logic [3:0]       r_cs, n_cs;
    logic [7:0]       r_isc, n_isc;
    logic [7:0]       r_ec, n_ec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HALTED;
            r_esc   <= 1'b0;
            r_sum   <= '0;
            r_bc    <= '0;
            r_cs    <= '0;
            r_isc   <= '0;
            r_ec    <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_esc   <= n_esc;
            r_sum   <= n_sum;
            r_bc    <= n_bc;
            r_cs    <= n_cs;
            r_isc   <= n_isc;
            r_ec    <= n_ec;
        end
    end

    logic [BC_W+LEN_W-1:0] bc_wide;
    logic [LEN_W-1:0]      bc_len;
    logic [3:0]            seq_next;
    logic [7:0]            seq_char;
    logic [7:0]            ec_inc;
    logic [7:0]            ch;
    logic [7:0]            b;
    logic                  in_packet;

    assign bc_wide   = {{LEN_W{1'b0}}, r_bc};
    assign bc_len    = bc_wide[LEN_W-1:0];
    assign seq_next  = (r_cs == SEQ_LAST) ? 4'd0 : (r_cs + 4'd1);
    assign seq_char  = {DIGIT_HI, r_cs};
    assign ec_inc    = (r_ec == COUNT_MAX) ? r_ec : (r_ec + 8'd1);
    assign b         = i_item.line_byte;
    assign ch        = r_esc ? (b & ESC_MASK) : b;
    assign in_packet = (r_phase == PH_DATA) || (r_phase == PH_SUM);

    t_out_item [MAX_RES-1:0] res;
    logic [1:0]              cnt;
    logic                    do_nak;

    always_comb begin
        n_phase = r_phase;
        n_esc   = r_esc;
        n_sum   = r_sum;
        n_bc    = r_bc;
        n_cs    = r_cs;
        n_isc   = r_isc;
        n_ec    = r_ec;
        res     = '0;
        cnt     = 2'd0;
        do_nak  = 1'b0;

        if (i_item.action == ACT_RESTART) begin
            if (in_packet) begin
                res[cnt].kind = KIND_ABANDON;
                cnt = cnt + 2'd1;
            end
            n_ec  = '0;
            n_cs  = '0;
            n_esc = 1'b0;
            n_bc  = '0;
            n_sum = '0;
            if (i_error_limit == 8'd0) begin
                res[cnt].kind = KIND_GAVEUP;
                cnt = cnt + 2'd1;
                n_phase = PH_HALTED;
            end else begin
                n_phase = PH_SEQ;
            end
        end else if (i_item.action != ACT_BYTE && i_item.action != ACT_TIMEOUT) begin
            cnt = 2'd0;
        end else if (r_phase == PH_HALTED) begin
            cnt = 2'd0;
        end else if (i_item.action == ACT_TIMEOUT) begin
            if (in_packet) begin
                res[cnt].kind = KIND_ABANDON;
                cnt = cnt + 2'd1;
            end
            do_nak = 1'b1;
        end else begin
            unique case (r_phase)
                PH_DLE: begin
                    if (b == CH_DLE) begin
                        n_phase = PH_B;
                    end else if (b == CH_ENQ) begin
                        res[cnt].kind          = KIND_TX;
                        res[cnt].value         = CH_DLE;
                        res[cnt].packet_length = LEN_W'(seq_char);
                        cnt = cnt + 2'd1;
                        res[cnt].kind  = KIND_TX;
                        res[cnt].value = seq_char;
                        cnt = cnt + 2'd1;
                    end
                end
                PH_B: begin
                    n_phase = (b == CH_B) ? PH_SEQ : PH_DLE;
                end
                PH_SEQ: begin
                    n_isc   = b;
                    n_sum   = sum_add(8'd0, b);
                    n_bc    = '0;
                    n_esc   = 1'b0;
                    n_phase = PH_DATA;
                end
                default: begin
                    if (!r_esc && b == CH_DLE) begin
                        n_esc = 1'b1;
                    end else begin
                        n_esc = 1'b0;
                        if (r_phase == PH_DATA) begin
                            if (!r_esc && ch == CH_ETX) begin
                                n_sum   = sum_add(r_sum, CH_ETX);
                                n_phase = PH_SUM;
                            end else if (r_bc >= BC_W'(PACKET_BYTES)) begin
                                res[cnt].kind = KIND_ABANDON;
                                cnt = cnt + 2'd1;
                                do_nak = 1'b1;
                            end else begin
                                res[cnt].kind  = KIND_DATA;
                                res[cnt].value = ch;
                                cnt = cnt + 2'd1;
                                n_bc  = r_bc + BC_W'(1);
                                n_sum = sum_add(r_sum, ch);
                            end
                        end else begin
                            if (ch != r_sum) begin
                                res[cnt].kind = KIND_ABANDON;
                                cnt = cnt + 2'd1;
                                do_nak = 1'b1;
                            end else if (r_isc == seq_char) begin
                                res[cnt].kind = KIND_ABANDON;
                                cnt = cnt + 2'd1;
                                res[cnt].kind          = KIND_TX;
                                res[cnt].value         = CH_DLE;
                                res[cnt].packet_length = LEN_W'(seq_char);
                                cnt = cnt + 2'd1;
                                res[cnt].kind  = KIND_TX;
                                res[cnt].value = seq_char;
                                cnt = cnt + 2'd1;
                                n_phase = PH_DLE;
                            end else if (r_isc != {DIGIT_HI, seq_next}) begin
                                res[cnt].kind = KIND_ABANDON;
                                cnt = cnt + 2'd1;
                                do_nak = 1'b1;
                            end else begin
                                n_cs = seq_next;
                                res[cnt].kind          = KIND_ACCEPT;
                                res[cnt].value         = {4'd0, seq_next};
                                res[cnt].packet_length = bc_len;
                                cnt = cnt + 2'd1;
                                n_ec    = '0;
                                n_phase = PH_DLE;
                            end
                        end
                    end
                end
            endcase
        end

        if (do_nak) begin
            res[cnt].kind  = KIND_TX;
            res[cnt].value = CH_NAK;
            cnt = cnt + 2'd1;
            n_ec  = ec_inc;
            n_esc = 1'b0;
            if (ec_inc >= i_error_limit) begin
                res[cnt].kind = KIND_GAVEUP;
                cnt = cnt + 2'd1;
                n_phase = PH_HALTED;
            end else begin
                n_phase = PH_DLE;
            end
        end

        if (cnt != 2'd0) begin
            res[cnt - 2'd1].last = 1'b1;
        end

        o_push.items = res;
        o_push.count = i_accept ? cnt : 2'd0;
    end

endmodule

### rtl/bpr_rfifo.sv
`timescale 1ns / 1ps

module bpr_rfifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bpr_pkg::t_push      i_push,
    input  logic                i_pop,
    output logic                o_room,
    output logic                o_valid,
    output bpr_pkg::t_out_item  o_item
);
    import bpr_pkg::*;

    localparam int PTR_W = $clog2(RES_DEPTH);
    localparam int CNT_W = $clog2(RES_DEPTH + 1);

    t_out_item [RES_DEPTH-1:0] r_mem;
    logic [PTR_W-1:0]          r_wr, r_rd;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic                      pop;

    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign o_room  = (r_cnt <= CNT_W'(RES_DEPTH - MAX_RES));
    assign pop     = i_pop && o_valid;
    assign n_cnt   = r_cnt + CNT_W'(i_push.count) - CNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + PTR_W'(i_push.count);
            r_rd  <= r_rd + PTR_W'(pop);
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (k < int'(i_push.count)) begin
                r_mem[r_wr + PTR_W'(k)] <= i_push.items[k];
            end
        end
    end

endmodule

### rtl/b_protocol_packet_receiver.sv
`timescale 1ns / 1ps
// The results of a taken item are written into the registered result queue and offered from its head.
// Throughput: 1 item per cycle while the result queue has room for three results;
//   results leave at 1 per cycle while the output is not stalled, so items with several results are paced by the queue.
// Reset (synchronous, active low): phase halted, counters and sums cleared,
//   error_limit back to 10, result queue emptied.

module b_protocol_packet_receiver #(
    parameter int PACKET_BYTES = bpr_pkg::PACKET_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  bpr_pkg::t_in_item   i_in,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output bpr_pkg::t_out_item  o_out,
    input  logic                i_out_stall,
    input  logic                i_cfg_valid,
    input  logic [7:0]          i_cfg_data,
    output logic                o_cfg_ready
);
    import bpr_pkg::*;

    logic       cfg_write;
    logic [7:0] r_error_limit;
    logic       room;
    logic       accept;
    t_push      push;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_limit <= ERROR_LIMIT_RST;
        end else if (cfg_write) begin
            r_error_limit <= i_cfg_data;
        end
    end

    assign o_in_stall = !room;
    assign accept     = i_in_valid && room;

    bpr_core #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_item        (i_in),
        .i_error_limit (r_error_limit),
        .o_push        (push)
    );

    bpr_rfifo u_rfifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (!i_out_stall),
        .o_room  (room),
        .o_valid (o_out_valid),
        .o_item  (o_out)
    );

endmodule

### rtl/bpr_checker.sv
`timescale 1ns / 1ps

module bpr_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                o_out_valid,
    input  bpr_pkg::t_out_item  o_out,
    input  logic                i_out_stall
);
    import bpr_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("results offered right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.kind <= KIND_GAVEUP)
        else $error("result kind out of range");

    a_final_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.kind == KIND_ACCEPT || o_out.kind == KIND_DATA ||
                        o_out.kind == KIND_GAVEUP) |-> o_out.last)
        else $error("accept, data or give-up result not marked last");

endmodule

bind b_protocol_packet_receiver bpr_checker u_bpr_checker (.*);

### dv/tb_b_protocol_packet_receiver.sv
`timescale 1ns / 1ps

module tb_b_protocol_packet_receiver;
    import bpr_pkg::*;

    localparam int         PACKET_LIMIT = PACKET_BYTES_DEF;
    localparam logic [1:0] ACT_UNUSED   = 2'd3;
    localparam int         HOLD_AT      = 90;
    localparam int         HOLD_CYCLES  = 300;

    typedef struct packed {
        t_phase           phase;
        logic             esc;
        logic [7:0]       sum;
        logic [LEN_W-1:0] count;
        logic [3:0]       seq;
        logic [7:0]       seq_char;
        logic [7:0]       errs;
        logic [7:0]       limit;
    } t_rx_state;

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    t_in_item   i_in = '0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_item  o_out;
    logic       i_out_stall = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [7:0] i_cfg_data = '0;
    logic       o_cfg_ready;

    t_rx_state  gen_st;
    t_rx_state  live_st;
    t_in_item   line_items[$];
    t_out_item  expected_results[$];
    int         items_pushed = 0;
    int         items_taken = 0;
    int         phase_items = 0;
    int         mismatch_count = 0;
    int         sender_idle_pct = 0;
    int         receiver_idle_pct = 0;
    int         hold_left = 0;
    bit         hold_done = 1'b0;
    bit         took_item = 1'b0;

    b_protocol_packet_receiver #(
        .PACKET_BYTES(PACKET_LIMIT)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out      (o_out),
        .i_out_stall(i_out_stall),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_cfg_ready(o_cfg_ready)
    );

    function automatic t_rx_state receiver_reset_state();
        t_rx_state st;
        st = '0;
        st.phase = PH_HALTED;
        st.limit = ERROR_LIMIT_RST;
        return st;
    endfunction

    // rotate left, then add with end-around carry
    function automatic logic [7:0] checksum_step(input logic [7:0] s, input logic [7:0] c);
        logic [8:0] t;
        t = {s, 1'b0};
        t = {1'b0, t[7:0] | {7'd0, t[8]}};
        t = t + {1'b0, c};
        return t[7:0] + 8'(t[8]);
    endfunction

    function automatic void add_result(inout t_push p, input logic [2:0] k,
                                       input logic [7:0] v, input logic [LEN_W-1:0] len);
        p.items[p.count] = '{kind: k, value: v, packet_length: len, last: 1'b0};
        p.count = p.count + 2'd1;
    endfunction

    function automatic void refuse_packet(inout t_rx_state st, inout t_push p);
        add_result(p, KIND_TX, CH_NAK, '0);
        if (st.errs != COUNT_MAX) st.errs = st.errs + 8'd1;
        st.esc = 1'b0;
        if (st.errs >= st.limit) begin
            add_result(p, KIND_GAVEUP, 8'h00, '0);
            st.phase = PH_HALTED;
        end else begin
            st.phase = PH_DLE;
        end
    endfunction

    // the DLE result carries the sequence digit character in its length field
    function automatic void resend_ack(inout t_rx_state st, inout t_push p);
        add_result(p, KIND_TX, CH_DLE, {2'b00, DIGIT_HI, st.seq});
        add_result(p, KIND_TX, {DIGIT_HI, st.seq}, '0);
    endfunction

    function automatic t_push predict_receiver(inout t_rx_state st, input t_in_item it);
        t_push      p;
        logic [7:0] ch;
        logic [3:0] nxt;
        logic       literal;
        logic       busy;
        p = '0;
        busy = (st.phase == PH_DATA) || (st.phase == PH_SUM);
        ch = it.line_byte;
        literal = 1'b0;
        nxt = (st.seq == SEQ_LAST) ? 4'd0 : st.seq + 4'd1;
        if (it.action == ACT_RESTART) begin
            if (busy) add_result(p, KIND_ABANDON, 8'h00, '0);
            st.errs = '0;
            st.seq = '0;
            st.esc = 1'b0;
            st.count = '0;
            st.sum = '0;
            if (st.limit == 8'd0) begin
                add_result(p, KIND_GAVEUP, 8'h00, '0);
                st.phase = PH_HALTED;
            end else begin
                st.phase = PH_SEQ;
            end
        end else if (it.action == ACT_UNUSED || st.phase == PH_HALTED) begin
            p.count = '0;
        end else if (it.action == ACT_TIMEOUT) begin
            if (busy) add_result(p, KIND_ABANDON, 8'h00, '0);
            refuse_packet(st, p);
        end else begin
            case (st.phase)
                PH_DLE: begin
                    if (ch == CH_DLE) st.phase = PH_B;
                    else if (ch == CH_ENQ) resend_ack(st, p);
                end
                PH_B: begin
                    st.phase = (ch == CH_B) ? PH_SEQ : PH_DLE;
                end
                PH_SEQ: begin
                    st.seq_char = ch;
                    st.sum = checksum_step(8'h00, ch);
                    st.count = '0;
                    st.esc = 1'b0;
                    st.phase = PH_DATA;
                end
                default: begin
                    if (st.esc) begin
                        st.esc = 1'b0;
                        ch = ch & ESC_MASK;
                        literal = 1'b1;
                    end else if (ch == CH_DLE) begin
                        st.esc = 1'b1;
                    end
                    if (!st.esc && st.phase == PH_DATA) begin
                        if (!literal && ch == CH_ETX) begin
                            st.sum = checksum_step(st.sum, CH_ETX);
                            st.phase = PH_SUM;
                        end else if (st.count >= PACKET_LIMIT) begin
                            add_result(p, KIND_ABANDON, 8'h00, '0);
                            refuse_packet(st, p);
                        end else begin
                            add_result(p, KIND_DATA, ch, '0);
                            st.count = st.count + 1'b1;
                            st.sum = checksum_step(st.sum, ch);
                        end
                    end else if (!st.esc) begin
                        if (ch != st.sum) begin
                            add_result(p, KIND_ABANDON, 8'h00, '0);
                            refuse_packet(st, p);
                        end else if (st.seq_char == {DIGIT_HI, st.seq}) begin
                            add_result(p, KIND_ABANDON, 8'h00, '0);
                            resend_ack(st, p);
                            st.phase = PH_DLE;
                        end else if (st.seq_char != {DIGIT_HI, nxt}) begin
                            add_result(p, KIND_ABANDON, 8'h00, '0);
                            refuse_packet(st, p);
                        end else begin
                            st.seq = nxt;
                            add_result(p, KIND_ACCEPT, {4'h0, nxt}, st.count);
                            st.errs = '0;
                            st.phase = PH_DLE;
                        end
                    end
                end
            endcase
        end
        if (p.count != 0) p.items[p.count - 2'd1].last = 1'b1;
        return p;
    endfunction

    function automatic void queue_item(input logic [1:0] a, input logic [7:0] b);
        t_in_item it;
        it = '{action: a, line_byte: b};
        void'(predict_receiver(gen_st, it));
        line_items.push_back(it);
        items_pushed++;
        if (a != ACT_UNUSED) phase_items++;
    endfunction

    // escape DLE and ETX always, other control bytes now and then
    function automatic void put_line_char(input logic [7:0] ch);
        if (ch == CH_DLE || ch == CH_ETX || (ch <= ESC_MASK && $urandom_range(4) == 0)) begin
            queue_item(ACT_BYTE, CH_DLE);
            queue_item(ACT_BYTE, {3'($urandom_range(7)), ch[4:0]});
        end else begin
            queue_item(ACT_BYTE, ch);
        end
    endfunction

    function automatic void queue_frame(input int len, input int seq_mode,
                                        input bit good_sum, input int cut_at);
        logic [3:0] nxt;
        logic [7:0] sc;
        logic [7:0] ch;
        while (gen_st.phase != PH_SEQ) begin
            case (gen_st.phase)
                PH_HALTED: queue_item(ACT_RESTART, 8'($urandom_range(255)));
                PH_DLE:    queue_item(ACT_BYTE, CH_DLE);
                PH_B:      queue_item(ACT_BYTE, CH_B);
                default:   queue_item(ACT_TIMEOUT, 8'($urandom_range(255)));
            endcase
        end
        nxt = (gen_st.seq == SEQ_LAST) ? 4'd0 : gen_st.seq + 4'd1;
        if (seq_mode < 75) sc = {DIGIT_HI, nxt};
        else if (seq_mode < 85) sc = {DIGIT_HI, gen_st.seq};
        else if (seq_mode < 93) sc = {DIGIT_HI, 4'($urandom_range(9))};
        else sc = 8'($urandom_range(255));
        queue_item(ACT_BYTE, sc);
        for (int i = 0; i < len; i++) begin
            if (i == cut_at) return;
            ch = ($urandom_range(99) < 30) ? 8'($urandom_range(31)) : 8'($urandom_range(255));
            put_line_char(ch);
        end
        queue_item(ACT_BYTE, CH_ETX);
        put_line_char(good_sum ? gen_st.sum : gen_st.sum ^ 8'($urandom_range(255, 1)));
    endfunction

    function automatic void random_sequence();
        int         r;
        int         len;
        int         cut;
        int         pick;
        logic [7:0] ch;
        r = $urandom_range(99);
        if (r < 10) begin
            repeat ($urandom_range(4, 1)) begin
                pick = $urandom_range(5);
                ch = (pick == 0) ? CH_DLE : (pick == 1) ? CH_ENQ : 8'($urandom_range(255));
                queue_item(ACT_BYTE, ch);
            end
        end else if (r < 14) begin
            queue_item(ACT_TIMEOUT, 8'($urandom_range(255)));
        end else if (r < 16) begin
            queue_item(ACT_UNUSED, 8'($urandom_range(255)));
        end else if (r < 19) begin
            queue_item(ACT_RESTART, 8'($urandom_range(255)));
        end else begin
            len = ($urandom_range(9) == 0) ? int'($urandom_range(60, 20))
                                           : int'($urandom_range(12));
            cut = (len > 0 && $urandom_range(19) == 0) ? int'($urandom_range(len - 1)) : -1;
            queue_frame(len, $urandom_range(99), $urandom_range(99) < 85, cut);
            if (cut >= 0) begin
                if ($urandom_range(2) == 0) queue_item(ACT_RESTART, 8'($urandom_range(255)));
                else queue_item(ACT_TIMEOUT, 8'($urandom_range(255)));
            end
        end
    endfunction

    function automatic void check_field(input string field, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic wait_idle();
        while (items_taken != items_pushed || expected_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic configure(input logic [7:0] limit_val, input int send_pct,
                             input int recv_pct);
        wait_idle();
        gen_st.limit = limit_val;
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= limit_val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sender_idle_pct   = send_pct;
        receiver_idle_pct = recv_pct;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [7:0] limit_val, input int send_pct,
                             input int recv_pct, input int n);
        configure(limit_val, send_pct, recv_pct);
        phase_items = 0;
        while (phase_items < n) random_sequence();
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || took_item) begin
            if (line_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                i_in       <= line_items.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (!hold_done && items_taken >= HOLD_AT) begin
            hold_done   <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < receiver_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        t_push     res;
        int        k;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: kind %0d value %0d", o_out.kind, o_out.value);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("kind", want.kind, o_out.kind);
                    check_field("value", want.value, o_out.value);
                    check_field("packet_length", want.packet_length, o_out.packet_length);
                    check_field("last", want.last, o_out.last);
                end
            end
            took_item = i_in_valid && !o_in_stall;
            if (took_item) begin
                res = predict_receiver(live_st, i_in);
                for (k = 0; k < res.count; k++) expected_results.push_back(res.items[k]);
                items_taken++;
            end
            if (i_cfg_valid && o_cfg_ready) live_st.limit = i_cfg_data;
        end
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        gen_st  = receiver_reset_state();
        live_st = receiver_reset_state();
        sender_idle_pct   = 12;
        receiver_idle_pct = 53;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // halted: drop bytes, timeouts and unused actions
        queue_item(ACT_BYTE, 8'h41);
        queue_item(ACT_TIMEOUT, 8'h00);
        queue_item(ACT_UNUSED, 8'hFF);
        queue_item(ACT_RESTART, 8'h00);
        queue_item(ACT_BYTE, {DIGIT_HI, 4'd1});
        queue_item(ACT_BYTE, 8'h00);
        queue_item(ACT_BYTE, 8'hFF);
        queue_item(ACT_BYTE, CH_DLE);
        queue_item(ACT_BYTE, 8'h63);
        queue_item(ACT_BYTE, CH_ETX);
        put_line_char(gen_st.sum);
        queue_item(ACT_BYTE, CH_ENQ);
        queue_item(ACT_BYTE, CH_DLE);
        queue_item(ACT_BYTE, 8'h41);
        // duplicate of the packet just taken
        queue_item(ACT_BYTE, CH_DLE);
        queue_item(ACT_BYTE, CH_B);
        queue_item(ACT_BYTE, {DIGIT_HI, 4'd1});
        queue_item(ACT_BYTE, CH_ETX);
        put_line_char(gen_st.sum);
        queue_item(ACT_TIMEOUT, 8'h00);
        queue_item(ACT_BYTE, CH_DLE);
        queue_item(ACT_BYTE, CH_B);
        queue_item(ACT_BYTE, {DIGIT_HI, 4'd2});
        queue_item(ACT_BYTE, 8'h7F);
        queue_item(ACT_TIMEOUT, 8'h00);
        queue_item(ACT_RESTART, 8'h00);

        configure(8'd0, 12, 53);
        queue_item(ACT_RESTART, 8'h00);
        queue_item(ACT_BYTE, CH_DLE);

        run_phase(8'd1, 12, 53, 20);
        run_phase(8'd255, 12, 53, 10);
        queue_frame(PACKET_LIMIT + 1, 0, 1'b1, -1);
        run_phase(8'd3, 53, 12, 20);
        run_phase(8'd200, 0, 0, 20);

        wait_idle();
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
